[sv/jmef_pkg.sv]
// Shared types and constants for the JPEG marker end finder.
// No dependencies; imported by the walker and the top level.
package jmef_pkg;

    localparam int unsigned LEN_W = 32;

    // Marker and data byte codes.
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_00  = 8'h00;
    localparam logic [7:0] MRK_SOI  = 8'hD8;
    localparam logic [7:0] MRK_EOI  = 8'hD9;
    localparam logic [7:0] MRK_TEM  = 8'h01;
    localparam logic [7:0] MRK_SOS  = 8'hDA;
    localparam logic [7:0] MRK_RSTL = 8'hD0;
    localparam logic [7:0] MRK_RSTH = 8'hD7;

    typedef enum logic [2:0] {
        ST_RUN  = 3'd0,
        ST_EOI  = 3'd1,
        ST_BAD  = 3'd2,
        ST_OUT  = 3'd3,
        ST_IDLE = 3'd4
    } t_status;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_SOI1      = 12'b0000_0000_0010,
        PH_MARK      = 12'b0000_0000_0100,
        PH_FILL      = 12'b0000_0000_1000,
        PH_LENHI     = 12'b0000_0001_0000,
        PH_LENLO     = 12'b0000_0010_0000,
        PH_LENHI_SOS = 12'b0000_0100_0000,
        PH_LENLO_SOS = 12'b0000_1000_0000,
        PH_PAY       = 12'b0001_0000_0000,
        PH_PAY_SOS   = 12'b0010_0000_0000,
        PH_ENT       = 12'b0100_0000_0000,
        PH_ENT_FF    = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [LEN_W-1:0]   length;
    } t_result;

    typedef struct packed {
        t_status status;
        t_phase  phase;
    } t_step;

endpackage

[sv/jmef_walker.sv]
// Marker walk phase machine with byte counter and segment length counters.
// Depends on jmef_pkg; instantiated by jpeg_marker_end_finder.
module jmef_walker #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  jmef_pkg::t_in_word i_word,
    output jmef_pkg::t_result  o_result
);
    import jmef_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic [7:0]             r_len_hi, n_len_hi;
    logic [15:0]            r_pay, n_pay;

    t_status     st;
    t_step       mk;
    logic [15:0] seg_len;
    logic [15:0] pay_next;
    logic        is_rst;

    // Marker code following an FF.
    function automatic t_step take_marker(input logic [7:0] m, input logic last);
        t_step s;
        s.phase = PH_MARK;
        if (m == MRK_EOI) begin
            s.status = ST_EOI;
        end else if (last) begin
            s.status = ST_OUT;
        end else if (m == MRK_TEM || (m >= MRK_RSTL && m <= MRK_RSTH)) begin
            s.status = ST_RUN;
        end else begin
            s.status = ST_RUN;
            s.phase  = (m == MRK_SOS) ? PH_LENHI_SOS : PH_LENHI;
        end
        return s;
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len_hi = r_len_hi;
        n_pay    = r_pay;
        st       = ST_IDLE;
        mk       = take_marker(i_word.data, i_word.last);
        is_rst   = i_word.data inside {[MRK_RSTL:MRK_RSTH]};
        seg_len  = {r_len_hi, i_word.data};
        pay_next = r_pay - 16'd1;

        if (i_word.first) begin
            n_pos = COUNT_WIDTH'(1);
            if (i_word.data != BYTE_FF) begin
                st = ST_BAD;
            end else if (i_word.last) begin
                st = ST_OUT;
            end else begin
                st      = ST_RUN;
                n_phase = PH_SOI1;
            end
        end else if (r_phase == PH_IDLE) begin
            st = ST_IDLE;
        end else if (r_pos == {COUNT_WIDTH{1'b1}}) begin
            st = ST_BAD;
        end else begin
            n_pos = r_pos + COUNT_WIDTH'(1);
            case (r_phase)
                PH_SOI1: begin
                    if (i_word.data != MRK_SOI) begin
                        st = ST_BAD;
                    end else if (i_word.last) begin
                        st = ST_OUT;
                    end else begin
                        st      = ST_RUN;
                        n_phase = PH_MARK;
                    end
                end
                PH_MARK: begin
                    // stray bytes between segments are dropped
                    if (i_word.last) begin
                        st = ST_OUT;
                    end else begin
                        st = ST_RUN;
                        if (i_word.data == BYTE_FF) n_phase = PH_FILL;
                    end
                end
                PH_FILL: begin
                    if (i_word.data == BYTE_FF) begin
                        st = i_word.last ? ST_OUT : ST_RUN;
                    end else begin
                        st = mk.status;
                        if (mk.status == ST_RUN) n_phase = mk.phase;
                    end
                end
                PH_LENHI, PH_LENHI_SOS: begin
                    n_len_hi = i_word.data;
                    if (i_word.last) begin
                        st = ST_OUT;
                    end else begin
                        st      = ST_RUN;
                        n_phase = (r_phase == PH_LENHI) ? PH_LENLO : PH_LENLO_SOS;
                    end
                end
                PH_LENLO, PH_LENLO_SOS: begin
                    if (seg_len < 16'd2) begin
                        st = ST_BAD;
                    end else if (i_word.last) begin
                        st = ST_OUT;
                    end else begin
                        st    = ST_RUN;
                        n_pay = seg_len - 16'd2;
                        if (seg_len == 16'd2) begin
                            n_phase = (r_phase == PH_LENLO_SOS) ? PH_ENT : PH_MARK;
                        end else begin
                            n_phase = (r_phase == PH_LENLO_SOS) ? PH_PAY_SOS : PH_PAY;
                        end
                    end
                end
                PH_PAY, PH_PAY_SOS: begin
                    if (i_word.last) begin
                        st = ST_OUT;
                    end else begin
                        st    = ST_RUN;
                        n_pay = pay_next;
                        if (pay_next == 16'd0) begin
                            n_phase = (r_phase == PH_PAY_SOS) ? PH_ENT : PH_MARK;
                        end
                    end
                end
                PH_ENT: begin
                    if (i_word.last) begin
                        st = ST_OUT;
                    end else begin
                        st = ST_RUN;
                        if (i_word.data == BYTE_FF) n_phase = PH_ENT_FF;
                    end
                end
                PH_ENT_FF: begin
                    // stuffed zero or restart pair: stay in entropy data
                    if (i_word.data == BYTE_00 || is_rst) begin
                        if (i_word.last) begin
                            st = ST_OUT;
                        end else begin
                            st      = ST_RUN;
                            n_phase = PH_ENT;
                        end
                    end else if (i_word.data == BYTE_FF) begin
                        st = i_word.last ? ST_OUT : ST_RUN;
                    end else begin
                        st = mk.status;
                        if (mk.status == ST_RUN) n_phase = mk.phase;
                    end
                end
                default: begin
                    st = ST_IDLE;
                end
            endcase
        end

        if (st == ST_EOI || st == ST_BAD || st == ST_OUT) begin
            n_phase = PH_IDLE;
        end

        o_result.status = st;
        o_result.length = (st == ST_EOI) ? LEN_W'(n_pos) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_pay   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_pay   <= n_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_len_hi <= n_len_hi;
        end
    end

endmodule

[sv/jpeg_marker_end_finder.sv]
// Top level: input word register, marker walker and result register.
// Depends on jmef_pkg and jmef_walker.
//
// Walks a JPEG candidate one byte per word, sustaining one byte per clock
// cycle while the result side does not stall. Each accepted byte returns
// exactly one result word via the input register and then the result
// register; the walker's phase machine updates once per byte. A
// byte with tuser set starts a new walk; tlast marks the final available
// byte. Result tuser is the walk status (0 in progress, 1 EOI found,
// 2 malformed, 3 data ran out, 4 idle) and tdata the stream length, nonzero
// only with EOI. The byte counter is COUNT_WIDTH bits wide; a walk that
// would exceed it reports malformed.
module jpeg_marker_end_finder #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] first_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] stream_length
    output logic [2:0]  o_m_tuser    // [2:0] walk_status
);
    import jmef_pkg::*;

    logic     r_in_valid;
    t_in_word r_in_word;
    logic     r_out_valid;
    t_result  r_out;
    t_result  result;
    logic     advance;
    logic     in_take;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    jmef_walker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word.data  <= i_s_tdata;
            r_in_word.first <= i_s_tuser;
            r_in_word.last  <= i_s_tlast;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.length;
    assign o_m_tuser  = r_out.status;

    // Only an EOI result carries a length.
    a_len_only_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_EOI) |-> (o_m_tdata == '0))
        else $error("length reported without EOI");

    // A held byte with room downstream becomes a result in the next cycle.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (!o_m_tvalid || i_m_tready)) |=> o_m_tvalid)
        else $error("byte lost between input and result register");

    // Input is held off only while both stages are full and the output stalls.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && o_m_tvalid && !i_m_tready))
        else $error("input stalled with room in the pipeline");

endmodule
